FILE: rtl/cvn_pkg.sv
// shared widths and types for the complex vector normalizer
package cvn_pkg;

  localparam int DATA_W           = 32;
  localparam int SUM_W            = 64;
  localparam int ELEM_W           = 2 * DATA_W;
  localparam int MAX_ELEMENTS_DEF = 64;
  localparam int QUO_W            = 17;

  typedef logic [DATA_W-1:0] word_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [QUO_W-1:0]  quo_t;

endpackage

FILE: rtl/cvn_in_if.sv
// element input channel and result channel interfaces
interface cvn_in_if import cvn_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t element_re;
  word_t element_im;
  logic  last;

  modport source(output valid, output element_re, output element_im, output last,
                 input ready);
  modport sink(input valid, input element_re, input element_im, input last,
               output ready);
endinterface

interface cvn_out_if import cvn_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t out_re;
  word_t out_im;
  word_t vector_norm;
  logic  out_last;
  logic  dropped;

  modport source(output valid, output out_re, output out_im, output vector_norm,
                 output out_last, output dropped, input ready);
  modport sink(input valid, input out_re, input out_im, input vector_norm,
               input out_last, input dropped, output ready);
endinterface

FILE: rtl/cvn_sqrt.sv
// iterative integer square root, one result bit per cycle
module cvn_sqrt import cvn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  sum_t  value,
  output logic  done,
  output word_t root
);

  sum_t rem_r, rem_nxt;
  sum_t root_r, root_nxt;
  sum_t bit_r, bit_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  sum_t trial;

  assign trial = root_r + bit_r;

  always_comb begin
    rem_nxt  = rem_r;
    root_nxt = root_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = value;
      root_nxt = '0;
      bit_nxt  = SUM_W'(1) << (SUM_W - 2);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= trial) begin
        rem_nxt  = rem_r - trial;
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign done = done_r;
  assign root = root_r[DATA_W-1:0];

endmodule

FILE: rtl/cvn_div.sv
// two-lane restoring divider sharing one divisor, one quotient bit per cycle
module cvn_div import cvn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t mag_re,
  input  word_t mag_im,
  input  word_t divisor,
  output logic  done,
  output quo_t  q_re,
  output quo_t  q_im
);

  localparam int CNT_W = $clog2(QUO_W);

  word_t p_re_r, p_re_nxt;
  word_t p_im_r, p_im_nxt;
  logic  b_re_r, b_re_nxt;
  logic  b_im_r, b_im_nxt;
  quo_t  q_re_r, q_re_nxt;
  quo_t  q_im_r, q_im_nxt;
  word_t d_r, d_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic  busy_r, busy_nxt;
  logic  done_r, done_nxt;
  logic [DATA_W:0] st_re;
  logic [DATA_W:0] st_im;

  // returns {quotient bit, new partial remainder}
  function automatic logic [DATA_W:0] div_step(word_t p, logic b, word_t d);
    logic [DATA_W:0] t;
    logic [DATA_W:0] r;
    t = {p, b};
    if (t >= {1'b0, d}) begin
      r = t - {1'b0, d};
      div_step = {1'b1, r[DATA_W-1:0]};
    end else begin
      div_step = {1'b0, t[DATA_W-1:0]};
    end
  endfunction

  assign st_re = div_step(p_re_r, b_re_r, d_r);
  assign st_im = div_step(p_im_r, b_im_r, d_r);

  always_comb begin
    p_re_nxt = p_re_r;
    p_im_nxt = p_im_r;
    b_re_nxt = b_re_r;
    b_im_nxt = b_im_r;
    q_re_nxt = q_re_r;
    q_im_nxt = q_im_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      p_re_nxt = {1'b0, mag_re[DATA_W-1:1]};
      p_im_nxt = {1'b0, mag_im[DATA_W-1:1]};
      b_re_nxt = mag_re[0];
      b_im_nxt = mag_im[0];
      q_re_nxt = '0;
      q_im_nxt = '0;
      d_nxt    = divisor;
      cnt_nxt  = CNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      p_re_nxt = st_re[DATA_W-1:0];
      p_im_nxt = st_im[DATA_W-1:0];
      b_re_nxt = 1'b0;
      b_im_nxt = 1'b0;
      q_re_nxt = {q_re_r[QUO_W-2:0], st_re[DATA_W]};
      q_im_nxt = {q_im_r[QUO_W-2:0], st_im[DATA_W]};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    p_re_r <= p_re_nxt;
    p_im_r <= p_im_nxt;
    b_re_r <= b_re_nxt;
    b_im_r <= b_im_nxt;
    q_re_r <= q_re_nxt;
    q_im_r <= q_im_nxt;
    d_r    <= d_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign q_re = q_re_r;
  assign q_im = q_im_r;

endmodule

FILE: rtl/complex_vector_normalize.sv
// Complex vector L2 normalizer. Elements are stored in a single-port element memory as they
// arrive. Each beat is taken while the squares of the previous element fold into the 64-bit
// saturating sum, then both parts are squared. After the beat marked last (or, when that beat
// is dropped, without squaring it) the square root is started and runs, then each stored
// element is read back and emitted. Passed through: read, load and the output beat. Scaled:
// read, load, a shift-subtract divider on both parts and the output beat. Each output beat
// waits for ready. No new element is taken until the whole vector has been emitted.
module complex_vector_normalize import cvn_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  word_t    cfg_wdata,
  cvn_in_if.sink   in_ch,
  cvn_out_if.source out_ch
);

  localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_SQST = 4'd3;
  localparam logic [3:0] S_SQRT = 4'd4;
  localparam logic [3:0] S_RD   = 4'd5;
  localparam logic [3:0] S_LD   = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] emit_r, emit_nxt;
  logic  overflow_r, overflow_nxt;
  logic  acc_pend_r, acc_pend_nxt;
  sum_t  sum_r, sum_nxt;
  sum_t  prod_re_r, prod_re_nxt;
  sum_t  prod_im_r, prod_im_nxt;
  word_t re_r, re_nxt;
  word_t im_r, im_nxt;
  logic  last_r, last_nxt;
  word_t norm_r, norm_nxt;
  logic  scale_r, scale_nxt;
  word_t min_norm_r;
  word_t out_re_r, out_re_nxt;
  word_t out_im_r, out_im_nxt;
  logic  out_last_r, out_last_nxt;
  logic  out_valid_r, out_valid_nxt;
  elem_t rdata_r;
  elem_t store_mem [MAX_ELEMENTS];

  logic  accept;
  logic  has_room;
  logic  mem_we;
  logic  mem_re;
  logic [SUM_W:0] acc_full;
  word_t mag_re;
  word_t mag_im;
  word_t rd_mag_re;
  word_t rd_mag_im;
  logic  sq_start;
  logic  sq_done;
  word_t sq_root;
  logic  div_start;
  logic  div_done;
  quo_t  q_re;
  quo_t  q_im;

  function automatic word_t mag32(word_t x);
    mag32 = x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
  endfunction

  assign accept    = in_ch.valid && in_ch.ready;
  assign has_room  = count_r < CNT_W'(MAX_ELEMENTS);
  assign mem_we    = accept && has_room;
  assign mem_re    = (state_r == S_RD);
  assign mag_re    = mag32(re_r);
  assign mag_im    = mag32(im_r);
  assign rd_mag_re = mag32(rdata_r[DATA_W-1:0]);
  assign rd_mag_im = mag32(rdata_r[ELEM_W-1:DATA_W]);
  assign acc_full  = {1'b0, sum_r} + {1'b0, prod_re_r} + {1'b0, prod_im_r};
  assign sq_start  = (state_r == S_SQST);
  assign div_start = (state_r == S_LD) && scale_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[count_r[IDX_W-1:0]] <= {in_ch.element_im, in_ch.element_re};
    end
    if (mem_re) begin
      rdata_r <= store_mem[emit_r[IDX_W-1:0]];
    end
  end

  cvn_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (sum_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  cvn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag_re  (rd_mag_re),
    .mag_im  (rd_mag_im),
    .divisor (norm_r),
    .done    (div_done),
    .q_re    (q_re),
    .q_im    (q_im)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    emit_nxt      = emit_r;
    overflow_nxt  = overflow_r;
    acc_pend_nxt  = 1'b0;
    sum_nxt       = sum_r;
    prod_re_nxt   = prod_re_r;
    prod_im_nxt   = prod_im_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    last_nxt      = last_r;
    norm_nxt      = norm_r;
    scale_nxt     = scale_r;
    out_re_nxt    = out_re_r;
    out_im_nxt    = out_im_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;

    // squares of the previous element fold in while the next beat may be taken
    if (acc_pend_r) begin
      sum_nxt = acc_full[SUM_W] ? {SUM_W{1'b1}} : acc_full[SUM_W-1:0];
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          re_nxt   = in_ch.element_re;
          im_nxt   = in_ch.element_im;
          last_nxt = in_ch.last;
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
            state_nxt = S_MUL;
          end else begin
            overflow_nxt = 1'b1;
            if (in_ch.last) begin
              state_nxt = S_ACC;
            end
          end
        end
      end
      S_MUL: begin
        prod_re_nxt  = SUM_W'(mag_re) * SUM_W'(mag_re);
        prod_im_nxt  = SUM_W'(mag_im) * SUM_W'(mag_im);
        acc_pend_nxt = 1'b1;
        state_nxt    = last_r ? S_ACC : S_IDLE;
      end
      S_ACC: begin
        state_nxt = S_SQST;
      end
      S_SQST: begin
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (sq_done) begin
          norm_nxt  = sq_root;
          scale_nxt = sq_root > min_norm_r;
          emit_nxt  = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_LD;
      end
      S_LD: begin
        out_last_nxt = (emit_r + CNT_W'(1)) == count_r;
        if (scale_r) begin
          state_nxt = S_DIV;
        end else begin
          out_re_nxt    = rdata_r[DATA_W-1:0];
          out_im_nxt    = rdata_r[ELEM_W-1:DATA_W];
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          out_re_nxt    = rdata_r[DATA_W-1] ? (~DATA_W'(q_re) + DATA_W'(1)) : DATA_W'(q_re);
          out_im_nxt    = rdata_r[ELEM_W-1] ? (~DATA_W'(q_im) + DATA_W'(1)) : DATA_W'(q_im);
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            sum_nxt      = '0;
            count_nxt    = '0;
            overflow_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end else begin
            emit_nxt  = emit_r + CNT_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      emit_r      <= '0;
      overflow_r  <= 1'b0;
      acc_pend_r  <= 1'b0;
      sum_r       <= '0;
      min_norm_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      emit_r      <= emit_nxt;
      overflow_r  <= overflow_nxt;
      acc_pend_r  <= acc_pend_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        min_norm_r <= cfg_wdata;
      end
    end
    prod_re_r  <= prod_re_nxt;
    prod_im_r  <= prod_im_nxt;
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    last_r     <= last_nxt;
    norm_r     <= norm_nxt;
    scale_r    <= scale_nxt;
    out_re_r   <= out_re_nxt;
    out_im_r   <= out_im_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_re      = out_re_r;
  assign out_ch.out_im      = out_im_r;
  assign out_ch.vector_norm = norm_r;
  assign out_ch.out_last    = out_last_r;
  assign out_ch.dropped     = overflow_r;

endmodule
